[src/sck_pkg.sv]
// Package for the SHA-256 counter-mode keystream cipher.
// Holds round constants, initial hash values, controller-datapath command types.
`timescale 1ns / 1ps
package sck_pkg;

  localparam int unsigned DataW      = 8;
  localparam int unsigned RegW       = 64;
  localparam int unsigned RegIdxW    = 1;
  localparam int unsigned BlockBytes = 32;
  localparam int unsigned PosW       = $clog2(BlockBytes);
  localparam int unsigned CtrW       = 32;
  localparam int unsigned RoundW     = 6;

  localparam logic [RegIdxW-1:0] RegDeviceId = 1'b0;
  localparam logic [RegIdxW-1:0] RegSalt     = 1'b1;

  localparam logic [63:0] SaltReset = 64'h6573706E6F6B6961;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] InitH =
    256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;

  // controller -> datapath
  typedef struct packed {
    logic load_key_msg;   // load schedule with key-derivation block
    logic load_ctr_msg;   // load schedule with keystream block
    logic round;          // run one compression round
    logic finish_key;     // latch digest as key
    logic finish_ks;      // latch digest as keystream block
  } dp_cmd_t;

  typedef struct packed {
    logic [RoundW-1:0] round_idx;
  } dp_stat_t;

endpackage

[src/sck_stream_if.sv]
// Valid/ready channel carrying one byte word and a last flag.
// Depends on sck_pkg.
`timescale 1ns / 1ps
interface sck_stream_if;
  logic                     valid;
  logic                     ready;
  logic [sck_pkg::DataW-1:0] data;
  logic                     last;
  modport source (output valid, output data, output last, input ready);
  modport sink (input valid, input data, input last, output ready);
endinterface

[src/sha256_ctr_keystream_xor_top.sv]
// Top level of the SHA-256 counter-mode keystream cipher.
// Uses sck_pkg, sck_stream_if, sck_ctrl, sck_datapath.
// Usage:
//   in_if (sink): one message byte word per handshake with a last flag.
//   out_if (source): the byte XORed with keystream, last flag copied.
//   cfg: cfg_we_i/cfg_idx_i/cfg_data_i; 0 = device_id, 1 = salt_prefix.
//   Write config only while idle; a write restarts the message and key.
// The SHA-256 core runs one round per cycle, 64 rounds a digest.
//   A byte mid-block uses the latched keystream block; the first byte of a
//   block waits for a keystream digest; the first byte after reset or a
//   config write waits for the key digest and then the keystream digest.
// One byte is in flight at a time; the next is accepted after the result
// register has been handed off. A stalled receiver holds the result and
// blocks new input. Reset clears key-ready, position and counter.
`timescale 1ns / 1ps
module sha256_ctr_keystream_xor_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sck_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  logic [sck_pkg::RegW-1:0]      cfg_data_i,
  sck_stream_if.sink                    in_if,
  sck_stream_if.source                  out_if
);
  import sck_pkg::*;

  logic [63:0]       dev_q, salt_q;
  dp_cmd_t           cmd;
  logic [RoundW-1:0] rnd;
  logic [CtrW-1:0]   ctr;
  logic [255:0]      ks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= '0;
      salt_q <= SaltReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegDeviceId) dev_q <= cfg_data_i;
      else salt_q <= cfg_data_i;
    end
  end

  sck_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .in_data_i(in_if.data), .in_last_i(in_if.last),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_data_o(out_if.data), .out_last_o(out_if.last),
    .cmd_o(cmd), .round_o(rnd), .ctr_o(ctr), .ks_i(ks)
  );

  sck_datapath u_dp (
    .clk_i, .cmd_i(cmd), .round_i(rnd),
    .device_id_i(dev_q), .salt_i(salt_q), .ctr_i(ctr), .ks_o(ks)
  );

endmodule

[src/sck_datapath.sv]
// SHA-256 datapath: schedule window, working variables, one round per cycle.
// Holds key and keystream block registers. Depends on sck_pkg.
`timescale 1ns / 1ps
module sck_datapath (
  input  logic                         clk_i,
  input  sck_pkg::dp_cmd_t             cmd_i,
  input  logic [sck_pkg::RoundW-1:0]   round_i,
  input  logic [63:0]                  device_id_i,
  input  logic [63:0]                  salt_i,
  input  logic [sck_pkg::CtrW-1:0]     ctr_i,
  output logic [255:0]                 ks_o
);
  import sck_pkg::*;

  logic [31:0]  w_q [16];
  logic [31:0]  v_q [8];
  logic [255:0] key_q;
  logic [255:0] ks_q;
  logic [511:0] blk;
  logic [31:0]  w15, w2, sg0, sg1, w_new, w_cur;
  logic [31:0]  s1, ch, t1, s0, mj, t2;
  logic [255:0] dig;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    blk = '0;
    if (cmd_i.load_key_msg) begin
      blk[511:448] = salt_i;
      for (int i = 0; i < 8; i++) begin
        blk[447-8*i -: 8] = device_id_i[8*i +: 8];
      end
      blk[383:376] = 8'h80;
      blk[15:0]    = 16'd128;
    end else begin
      blk[511:256] = key_q;
      for (int i = 0; i < 4; i++) begin
        blk[255-8*i -: 8] = ctr_i[8*i +: 8];
      end
      blk[223:216] = 8'h80;
      blk[15:0]    = 16'd288;
    end
  end

  // rolling 16-word window: w_q[0] is always the current word
  always_comb begin
    w15   = w_q[1];
    w2    = w_q[14];
    sg0   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    sg1   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    w_new = w_q[0] + sg0 + w_q[9] + sg1;
    w_cur = w_q[0];
    s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + s1 + ch + RoundK[round_i] + w_cur;
    s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = s0 + mj;
    for (int i = 0; i < 8; i++) begin
      dig[255-32*i -: 32] = InitH[255-32*i -: 32] + v_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key_msg || cmd_i.load_ctr_msg) begin
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= blk[511-32*i -: 32];
      end
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= InitH[255-32*i -: 32];
      end
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (cmd_i.finish_key) key_q <= dig;
    if (cmd_i.finish_ks)  ks_q  <= dig;
  end

  assign ks_o = ks_q;

endmodule

[src/sck_ctrl.sv]
// Controller: key derivation, block refill sequencing, byte position/counter,
// handshakes and output register. Depends on sck_pkg.
`timescale 1ns / 1ps
module sck_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sck_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sck_pkg::DataW-1:0]     in_data_i,
  input  logic                          in_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sck_pkg::DataW-1:0]     out_data_o,
  output logic                          out_last_o,
  output sck_pkg::dp_cmd_t              cmd_o,
  output logic [sck_pkg::RoundW-1:0]    round_o,
  output logic [sck_pkg::CtrW-1:0]      ctr_o,
  input  logic [255:0]                  ks_i
);
  import sck_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StKeyLd = 3'd1;
  localparam logic [2:0] StKeyRd = 3'd2;
  localparam logic [2:0] StKsLd  = 3'd3;
  localparam logic [2:0] StKsRd  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]       st_q, st_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic             key_rdy_q, key_rdy_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [CtrW-1:0]  ctr_q, ctr_d;
  logic [DataW-1:0] dat_q, dat_d;
  logic             lst_q, lst_d;
  logic             ov_q, ov_d;
  logic             cfg_hit;
  logic             acc;
  logic             fin_q;
  logic             out_go;

  // both indexes of a 1-bit index are valid registers
  assign cfg_hit = cfg_we_i && (cfg_idx_i == RegDeviceId || cfg_idx_i == RegSalt);
  assign in_ready_o = (st_q == StIdle) && !ov_q;
  assign acc = in_valid_i && in_ready_o;
  // result is formed once any fresh keystream block has been latched and the output register is free
  assign out_go = (st_q == StOut) && !ov_q && !fin_q;

  always_comb begin
    st_d = st_q; rnd_d = rnd_q; key_rdy_d = key_rdy_q;
    pos_d = pos_q; ctr_d = ctr_q; dat_d = dat_q; lst_d = lst_q;
    ov_d = ov_q && !out_ready_i;
    cmd_o = '0;
    case (st_q)
      StIdle: begin
        if (acc) begin
          dat_d = in_data_i;
          lst_d = in_last_i;
          if (!key_rdy_q) begin
            st_d = StKeyLd;
          end else if (pos_q == '0) begin
            st_d = StKsLd;
          end else begin
            st_d = StOut;
          end
        end
      end
      StKeyLd: begin
        cmd_o.load_key_msg = 1'b1;
        rnd_d = '0;
        st_d = StKeyRd;
      end
      StKeyRd: begin
        cmd_o.round = 1'b1;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == '1) begin
          st_d = StKsLd;
        end
      end
      StKsLd: begin
        // key digest is final in the cycle after the last key round
        if (!key_rdy_q) begin
          cmd_o.finish_key = 1'b1;
          key_rdy_d = 1'b1;
        end
        cmd_o.load_ctr_msg = key_rdy_q;
        rnd_d = '0;
        st_d = key_rdy_q ? StKsRd : StKsLd;
        if (key_rdy_q && pos_q != '0) st_d = StOut;
      end
      StKsRd: begin
        cmd_o.round = 1'b1;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == '1) begin
          st_d = StOut;
        end
      end
      StOut: begin
        // latch digest on the way through when a block was just computed
        cmd_o.finish_ks = fin_q;
        if (out_go) begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
    if (out_go) begin
      ov_d = 1'b1;
      if (lst_q) begin
        pos_d = '0;
        ctr_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
        if (pos_q == '1) ctr_d = ctr_q + 1'b1;
      end
    end
    if (cfg_hit) begin
      key_rdy_d = 1'b0;
      pos_d = '0;
      ctr_d = '0;
    end
  end

  // digest capture: flagged in the cycle after the final round
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
    end else begin
      fin_q <= (st_q == StKsRd) && (rnd_q == '1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; rnd_q <= '0; key_rdy_q <= 1'b0;
      pos_q <= '0; ctr_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; rnd_q <= rnd_d; key_rdy_q <= key_rdy_d;
      pos_q <= pos_d; ctr_q <= ctr_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q <= dat_d;
    lst_q <= lst_d;
  end

  logic [DataW-1:0] obyte_q;
  logic             olast_q;
  logic [255:0]     ksv;
  assign ksv = ks_i;
  always_ff @(posedge clk_i) begin
    if (out_go) begin
      obyte_q <= dat_q ^ ksv[255 - 8*pos_q -: 8];
      olast_q <= lst_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o = obyte_q;
  assign out_last_o = olast_q;
  assign round_o = rnd_q;
  assign ctr_o = ctr_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !in_ready_o) else $error("accept while busy");
  a_pos_clear_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (pos_q == '0 && ctr_q == '0 && !key_rdy_q)) else $error("cfg restart");
  a_key_before_ks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StKsRd) |-> key_rdy_q) else $error("keystream without key");
`endif

endmodule

[bench/tb_sha256_ctr_keystream_xor_top.sv]
// Testbench for the SHA-256 counter-mode keystream XOR cipher.
// Depends on sck_pkg, sck_stream_if and sha256_ctr_keystream_xor_top.
`timescale 1ns / 1ps

class keystream_scoreboard;
  typedef struct {
    logic [7:0] data;
    logic       last;
  } cipher_word_t;

  cipher_word_t pending_q[$];
  int           error_count;

  logic [63:0]  device_id;
  logic [63:0]  salt;
  logic [255:0] key;
  bit           key_valid;
  logic [255:0] block;
  logic [4:0]   pos;
  logic [31:0]  ctr;

  function new();
    device_id   = '0;
    salt        = sck_pkg::SaltReset;
    key_valid   = 1'b0;
    pos         = '0;
    ctr         = '0;
    error_count = 0;
  endfunction

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Single-block SHA-256 over a byte message of at most 55 bytes.
  function automatic logic [255:0] sha_single(logic [7:0] msg[], int n);
    logic [7:0]  blk[64];
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] s0, s1, t1, t2, ch, mj;
    logic [255:0] dig;
    foreach (blk[i]) blk[i] = 8'h00;
    for (int i = 0; i < n; i++) blk[i] = msg[i];
    blk[n]  = 8'h80;
    blk[62] = 8'((n * 8) >> 8);
    blk[63] = 8'(n * 8);
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = sck_pkg::InitH[255 - 32*i -: 32];
    for (int r = 0; r < 64; r++) begin
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + sck_pkg::RoundK[r] + w[r];
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) dig[255 - 32*i -: 32] = sck_pkg::InitH[255 - 32*i -: 32] + v[i];
    return dig;
  endfunction

  function void set_reg(logic idx, logic [63:0] val);
    if (idx == sck_pkg::RegDeviceId) device_id = val;
    else salt = val;
    key_valid = 1'b0;
    pos = '0;
    ctr = '0;
  endfunction

  function void note_input(logic [7:0] data, logic last);
    logic [7:0]   msg[];
    cipher_word_t exp;
    if (!key_valid) begin
      msg = new[16];
      for (int i = 0; i < 8; i++) begin
        msg[i]     = salt[63 - 8*i -: 8];
        msg[8 + i] = device_id[8*i +: 8];
      end
      key = sha_single(msg, 16);
      key_valid = 1'b1;
    end
    if (pos == 0) begin
      msg = new[36];
      for (int i = 0; i < 32; i++) msg[i] = key[255 - 8*i -: 8];
      for (int i = 0; i < 4; i++) msg[32 + i] = ctr[8*i +: 8];
      block = sha_single(msg, 36);
    end
    exp.data = data ^ block[255 - 8*pos -: 8];
    exp.last = last;
    pending_q.push_back(exp);
    if (last) begin
      pos = '0;
      ctr = '0;
    end else begin
      pos = pos + 5'd1;
      if (pos == 0) ctr = ctr + 32'd1;
    end
  endfunction

  function void check_output(logic [7:0] data, logic last);
    cipher_word_t exp;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected word data=%h last=%b", $time, data, last);
      error_count++;
      return;
    end
    exp = pending_q.pop_front();
    if (data !== exp.data) begin
      $display("%0t: data mismatch expected %h actual %h", $time, exp.data, data);
      error_count++;
    end
    if (last !== exp.last) begin
      $display("%0t: last mismatch expected %b actual %b", $time, exp.last, last);
      error_count++;
    end
  endfunction
endclass

module tb_sha256_ctr_keystream_xor_top;
  import sck_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = '0;
  logic [RegW-1:0]   cfg_data_i = '0;
  int                burst_left = 0;
  int                stall_mode = 0;

  sck_stream_if in_if ();
  sck_stream_if out_if ();

  keystream_scoreboard sb = new();

  sha256_ctr_keystream_xor_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    in_if.last   = 1'b0;
    out_if.ready = 1'b0;
  end

  // receiver: stall pattern changes every so often; mode 0 never stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_output(out_if.data, out_if.last);
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 3) != 0);
      2: out_if.ready <= ($urandom_range(0, 1) != 0);
      default: out_if.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // valid stays high across a burst; it drops only for a gap or at drain
  task automatic send_word(logic [7:0] data, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= data;
    in_if.last  <= last;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    sb.note_input(data, last);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_word(8'($urandom), i == len - 1);
  endtask

  task automatic drain_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset key, data extremes, block boundary, last restart
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hA5, 1'b1);
    send_word(8'h5A, 1'b1);
    for (int i = 0; i < 34; i++) send_word(8'(i * 37), 1'b0);
    send_word(8'hFF, 1'b1);
    drain_idle();
    write_reg(RegDeviceId, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegSalt, 64'h0);
    send_message(5);
    drain_idle();

    // random phases with fresh registers between them
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: r = 64'h0;
        1: r = 64'hFFFF_FFFF_FFFF_FFFF;
        default: r = {$urandom, $urandom};
      endcase
      write_reg(phase[0] ? RegSalt : RegDeviceId, r);
      for (int n = 0; n < 215; ) begin
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 100) : $urandom_range(1, 40);
        send_message(len);
        n += len;
      end
      drain_idle();
    end

    if (sb.error_count == 0 && sb.pending_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
